// File: rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV conversion pipeline.
package rhc_pkg;

    localparam int CH_W   = 8;
    localparam int HUE_W  = 15;
    localparam int HNUM_W = 14;
    localparam int SNUM_W = 16;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] hi;
        sector_t         sector;
        logic            neg;
        logic            gray;
    } side_t;

endpackage

// File: rtl/rhc_front.sv
// Front stage: max, min, delta, hue sector and scaled dividends.
module rhc_front #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    up_valid,
    output logic                                    up_ready,
    input  logic [rhc_pkg::CH_W-1:0]                red,
    input  logic [rhc_pkg::CH_W-1:0]                green,
    input  logic [rhc_pkg::CH_W-1:0]                blue,
    output logic                                    dn_valid,
    input  logic                                    dn_ready,
    output logic [rhc_pkg::HNUM_W+HUE_FRAC_BITS-1:0] rem_h,
    output logic [rhc_pkg::SNUM_W-1:0]              rem_s,
    output logic [rhc_pkg::CH_W-1:0]                delta,
    output rhc_pkg::side_t                          side
);
    import rhc_pkg::*;

    localparam int RH_W = HNUM_W + HUE_FRAC_BITS;

    logic [CH_W-1:0]   hi;
    logic [CH_W-1:0]   lo;
    logic [CH_W-1:0]   dlt;
    logic [CH_W-1:0]   op_a;
    logic [CH_W-1:0]   op_b;
    logic [CH_W-1:0]   mag;
    logic [HNUM_W-1:0] hnum;
    logic [SNUM_W-1:0] snum;
    side_t             side_next;

    logic              valid_reg;
    logic [RH_W-1:0]   rem_h_reg;
    logic [SNUM_W-1:0] rem_s_reg;
    logic [CH_W-1:0]   delta_reg;
    side_t             side_reg;

    always_comb
    begin
        hi = (red > green) ? red : green;
        hi = (hi > blue) ? hi : blue;
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;
        dlt = hi - lo;

        if (red >= hi)
        begin
            side_next.sector = SEC_RED;
            op_a = green;
            op_b = blue;
        end
        else if (green >= hi)
        begin
            side_next.sector = SEC_GREEN;
            op_a = blue;
            op_b = red;
        end
        else
        begin
            side_next.sector = SEC_BLUE;
            op_a = red;
            op_b = green;
        end

        side_next.neg  = op_a < op_b;
        side_next.hi   = hi;
        side_next.gray = (dlt == '0);
        mag  = side_next.neg ? (op_b - op_a) : (op_a - op_b);
        // |diff| * 60
        hnum = ({{(HNUM_W-CH_W){1'b0}}, mag} << 6) - ({{(HNUM_W-CH_W){1'b0}}, mag} << 2);
        // delta * 255
        snum = {dlt, {CH_W{1'b0}}} - {{(SNUM_W-CH_W){1'b0}}, dlt};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_h_reg <= {hnum, {HUE_FRAC_BITS{1'b0}}};
            rem_s_reg <= snum;
            delta_reg <= dlt;
            side_reg  <= side_next;
        end
    end

    assign dn_valid = valid_reg;
    assign rem_h    = rem_h_reg;
    assign rem_s    = rem_s_reg;
    assign delta    = delta_reg;
    assign side     = side_reg;

endmodule

// File: rtl/rhc_div.sv
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
module rhc_div #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     up_valid,
    output logic                                     up_ready,
    input  logic [rhc_pkg::HNUM_W+HUE_FRAC_BITS-1:0] rem_h,
    input  logic [rhc_pkg::SNUM_W-1:0]               rem_s,
    input  logic [rhc_pkg::CH_W-1:0]                 delta,
    input  rhc_pkg::side_t                           side,
    output logic                                     dn_valid,
    input  logic                                     dn_ready,
    output logic [HUE_FRAC_BITS+5:0]                 quo_h,
    output logic [rhc_pkg::CH_W-1:0]                 quo_s,
    output rhc_pkg::side_t                           side_out
);
    import rhc_pkg::*;

    localparam int RH_W = HNUM_W + HUE_FRAC_BITS;
    localparam int QH   = HUE_FRAC_BITS + 6;
    localparam int NSTG = (QH > CH_W) ? QH : CH_W;

    logic              in_v  [NSTG];
    logic [RH_W-1:0]   in_rh [NSTG];
    logic [SNUM_W-1:0] in_rs [NSTG];
    logic [QH-1:0]     in_qh [NSTG];
    logic [CH_W-1:0]   in_qs [NSTG];
    logic [CH_W-1:0]   in_dh [NSTG];
    side_t             in_sd [NSTG];

    logic              st_v  [NSTG];
    logic [RH_W-1:0]   st_rh [NSTG];
    logic [SNUM_W-1:0] st_rs [NSTG];
    logic [QH-1:0]     st_qh [NSTG];
    logic [CH_W-1:0]   st_qs [NSTG];
    logic [CH_W-1:0]   st_dh [NSTG];
    side_t             st_sd [NSTG];

    logic              rdy [NSTG+1];

    assign rdy[NSTG] = dn_ready;
    assign up_ready  = rdy[0];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stg
            logic              valid_reg;
            logic [RH_W-1:0]   rh_reg;
            logic [SNUM_W-1:0] rs_reg;
            logic [QH-1:0]     qh_reg;
            logic [CH_W-1:0]   qs_reg;
            logic [CH_W-1:0]   dh_reg;
            side_t             sd_reg;
            logic [RH_W-1:0]   rh_next;
            logic [SNUM_W-1:0] rs_next;
            logic [QH-1:0]     qh_next;
            logic [CH_W-1:0]   qs_next;

            if (s == 0)
            begin : g_first
                assign in_v[s]  = up_valid;
                assign in_rh[s] = rem_h;
                assign in_rs[s] = rem_s;
                assign in_qh[s] = '0;
                assign in_qs[s] = '0;
                assign in_dh[s] = delta;
                assign in_sd[s] = side;
            end
            else
            begin : g_next
                assign in_v[s]  = st_v[s-1];
                assign in_rh[s] = st_rh[s-1];
                assign in_rs[s] = st_rs[s-1];
                assign in_qh[s] = st_qh[s-1];
                assign in_qs[s] = st_qs[s-1];
                assign in_dh[s] = st_dh[s-1];
                assign in_sd[s] = st_sd[s-1];
            end

            if (s < QH)
            begin : g_hue
                localparam int KH = QH - 1 - s;
                logic [RH_W-1:0] trial_h;
                assign trial_h = {{(RH_W-CH_W){1'b0}}, in_dh[s]} << KH;
                always_comb
                begin
                    rh_next = in_rh[s];
                    qh_next = in_qh[s];
                    if (in_rh[s] >= trial_h)
                    begin
                        rh_next     = in_rh[s] - trial_h;
                        qh_next[KH] = 1'b1;
                    end
                end
            end
            else
            begin : g_hue_pass
                assign rh_next = in_rh[s];
                assign qh_next = in_qh[s];
            end

            if (s < CH_W)
            begin : g_sat
                localparam int KS = CH_W - 1 - s;
                logic [SNUM_W-1:0] trial_s;
                assign trial_s = {{(SNUM_W-CH_W){1'b0}}, in_sd[s].hi} << KS;
                always_comb
                begin
                    rs_next = in_rs[s];
                    qs_next = in_qs[s];
                    if (in_rs[s] >= trial_s)
                    begin
                        rs_next     = in_rs[s] - trial_s;
                        qs_next[KS] = 1'b1;
                    end
                end
            end
            else
            begin : g_sat_pass
                assign rs_next = in_rs[s];
                assign qs_next = in_qs[s];
            end

            assign rdy[s] = !valid_reg || rdy[s+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= 1'b0;
                end
                else if (rdy[s])
                begin
                    valid_reg <= in_v[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && in_v[s])
                begin
                    rh_reg <= rh_next;
                    rs_reg <= rs_next;
                    qh_reg <= qh_next;
                    qs_reg <= qs_next;
                    dh_reg <= in_dh[s];
                    sd_reg <= in_sd[s];
                end
            end

            assign st_v[s]  = valid_reg;
            assign st_rh[s] = rh_reg;
            assign st_rs[s] = rs_reg;
            assign st_qh[s] = qh_reg;
            assign st_qs[s] = qs_reg;
            assign st_dh[s] = dh_reg;
            assign st_sd[s] = sd_reg;
        end
    endgenerate

    assign dn_valid = st_v[NSTG-1];
    assign quo_h    = st_qh[NSTG-1];
    assign quo_s    = st_qs[NSTG-1];
    assign side_out = st_sd[NSTG-1];

endmodule

// File: rtl/rhc_back.sv
// Back stage: sector offset, sign, wrap, gray override and output register.
module rhc_back #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [HUE_FRAC_BITS+5:0]    quo_h,
    input  logic [rhc_pkg::CH_W-1:0]    quo_s,
    input  rhc_pkg::side_t              side,
    output logic                        hsv_valid,
    input  logic                        hsv_stall,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::CH_W-1:0]    saturation,
    output logic [rhc_pkg::CH_W-1:0]    brightness,
    output logic                        gray_flag
);
    import rhc_pkg::*;

    localparam int HW    = $clog2(360 * (2 ** HUE_FRAC_BITS) + 1);
    localparam int HFW   = (HW > HUE_W) ? HW : HUE_W;
    localparam int SIXTH = 60 * (2 ** HUE_FRAC_BITS);

    logic [HFW-1:0]  q;
    logic [HFW-1:0]  hue_full;
    logic [HUE_W-1:0] hue_next;
    logic [CH_W-1:0]  sat_next;

    logic             valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [CH_W-1:0]  sat_reg;
    logic [CH_W-1:0]  bri_reg;
    logic             gray_reg;

    always_comb
    begin
        q = HFW'(quo_h);
        case (side.sector)
            SEC_RED:
            begin
                if (side.neg && (q != '0))
                    hue_full = HFW'(6 * SIXTH) - q;
                else
                    hue_full = q;
            end
            SEC_GREEN:
            begin
                hue_full = side.neg ? (HFW'(2 * SIXTH) - q) : (HFW'(2 * SIXTH) + q);
            end
            SEC_BLUE:
            begin
                hue_full = side.neg ? (HFW'(4 * SIXTH) - q) : (HFW'(4 * SIXTH) + q);
            end
            default:
            begin
                hue_full = '0;
            end
        endcase
        hue_next = side.gray ? '0 : hue_full[HUE_W-1:0];
        sat_next = side.gray ? '0 : quo_s;
    end

    assign up_ready = !valid_reg || !hsv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            bri_reg  <= side.hi;
            gray_reg <= side.gray;
        end
    end

    assign hsv_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;
    assign gray_flag  = gray_reg;

endmodule

// File: rtl/rgb_to_hsv_convert_core.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------------------
//  pixel   | pix_valid | pix_stall | red, green, blue
//  hsv     | hsv_valid | hsv_stall | hue, saturation, brightness, gray_flag
//
// One word per cycle sustained while hsv_stall is low. Each pixel passes through
// the front stage, one restoring-divider stage per quotient bit of the wider
// of hue and saturation dividers (which run alongside) and the output register.
// Reset empties every stage. A stall on hsv only holds stages that are full;
// bubbles close up, so pix_stall rises only when the whole pipe is full.
module rgb_to_hsv_convert_core #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  logic [rhc_pkg::CH_W-1:0]    red,
    input  logic [rhc_pkg::CH_W-1:0]    green,
    input  logic [rhc_pkg::CH_W-1:0]    blue,
    output logic                        hsv_valid,
    input  logic                        hsv_stall,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::CH_W-1:0]    saturation,
    output logic [rhc_pkg::CH_W-1:0]    brightness,
    output logic                        gray_flag
);
    import rhc_pkg::*;

    localparam int RH_W = HNUM_W + HUE_FRAC_BITS;
    localparam int QH   = HUE_FRAC_BITS + 6;

    logic              front_ready;
    logic              f_valid;
    logic              f_ready;
    logic [RH_W-1:0]   f_rem_h;
    logic [SNUM_W-1:0] f_rem_s;
    logic [CH_W-1:0]   f_delta;
    side_t             f_side;

    logic              d_valid;
    logic              d_ready;
    logic [QH-1:0]     d_quo_h;
    logic [CH_W-1:0]   d_quo_s;
    side_t             d_side;

    rhc_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid),
        .up_ready (front_ready),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .dn_valid (f_valid),
        .dn_ready (f_ready),
        .rem_h    (f_rem_h),
        .rem_s    (f_rem_s),
        .delta    (f_delta),
        .side     (f_side)
    );

    rhc_div #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .rem_h    (f_rem_h),
        .rem_s    (f_rem_s),
        .delta    (f_delta),
        .side     (f_side),
        .dn_valid (d_valid),
        .dn_ready (d_ready),
        .quo_h    (d_quo_h),
        .quo_s    (d_quo_s),
        .side_out (d_side)
    );

    rhc_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (d_valid),
        .up_ready   (d_ready),
        .quo_h      (d_quo_h),
        .quo_s      (d_quo_s),
        .side       (d_side),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .gray_flag  (gray_flag)
    );

    assign pix_stall = !front_ready;

endmodule
